[rtl/core/swsb_pkg.sv]
// ----------------------------------------------------------------------------
// swsb_pkg
// Types and codes shared by the single-wire serial byte engine modules.
// ----------------------------------------------------------------------------
package swsb_pkg;

  localparam int unsigned BitPeriodW   = 16;
  localparam logic [BitPeriodW-1:0] BitPeriodReset = 16'd104;
  localparam int unsigned InDataW      = 16;
  localparam int unsigned OutDataW     = 16;

  // request kind carried on the input tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ARM  = 1'b1;

  // transfer modes
  localparam logic [1:0] MODE_REPLY = 2'd0;
  localparam logic [1:0] MODE_SEND  = 2'd1;
  localparam logic [1:0] MODE_RECV  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // pin drive codes: bit 1 is drive enable, bit 0 level or pull-up
  localparam logic [1:0] PIN_RELEASED = 2'd0;
  localparam logic [1:0] PIN_PULLUP   = 2'd1;
  localparam logic [1:0] PIN_DRIVE_LO = 2'd2;
  localparam logic [1:0] PIN_DRIVE_HI = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ARMED    = 4'd1,
    PH_HALF     = 4'd2,
    PH_GAP      = 4'd3,
    PH_PREAMBLE = 4'd4,
    PH_SWAIT    = 4'd5,
    PH_SPULL    = 4'd6,
    PH_TXDATA   = 4'd7,
    PH_RXDATA   = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [1:0]            active_mode;
    logic [BitPeriodW-1:0] tick_timer;
    logic [3:0]            bit_index;
    logic [7:0]            shift_reg;
    logic [1:0]            pin_drive;
  } engine_state_t;

  // field order matches the output tdata packing, lowest bit last here
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       tx_done;
    logic       reply_started;
    logic       busy_res;
    logic       drive_level;
    logic       drive_enable;
  } engine_result_t;

endpackage

[rtl/core/swsb_step.sv]
// ----------------------------------------------------------------------------
// swsb_step
// One-tick update of the engine: next state and result from the current
// state, the incoming request and the bit period.
// ----------------------------------------------------------------------------
module swsb_step import swsb_pkg::*; (
  input  engine_state_t          cur,
  input  logic                   cmd,
  input  logic [1:0]             op_mode,
  input  logic [7:0]             tx_byte,
  input  logic                   line_level,
  input  logic [BitPeriodW-1:0]  bit_period,
  output engine_state_t          nxt,
  output engine_result_t         res
);

  logic [BitPeriodW-1:0] half;
  logic [BitPeriodW-1:0] wait_len;
  logic [BitPeriodW-1:0] timer_inc;
  logic                  wait_done;
  logic [3:0]            idx_inc;
  logic [7:0]            shift_in;
  logic                  tx_bit_first;
  logic                  tx_bit_next;
  logic                  rs;
  logic                  td;
  logic                  rv;

  always_comb begin
    half      = bit_period >> 1;
    wait_len  = (cur.phase == PH_HALF) ? half : bit_period;
    timer_inc = cur.tick_timer + BitPeriodW'(1);
    wait_done = (wait_len == '0) || (timer_inc >= wait_len);
    idx_inc   = cur.bit_index + 4'd1;
    shift_in  = {cur.shift_reg[6:0], line_level};
    // msb first: bit 7 goes out first
    tx_bit_first = cur.shift_reg[3'd7 - cur.bit_index[2:0]];
    tx_bit_next  = cur.shift_reg[3'd7 - idx_inc[2:0]];
  end

  always_comb begin
    nxt = cur;
    rs  = 1'b0;
    td  = 1'b0;
    rv  = 1'b0;
    if (cmd == CMD_ARM && op_mode != MODE_NONE) begin
      nxt.phase       = PH_ARMED;
      nxt.active_mode = op_mode;
      nxt.shift_reg   = (op_mode == MODE_RECV) ? 8'd0 : tx_byte;
      nxt.tick_timer  = '0;
      nxt.bit_index   = 4'd0;
      nxt.pin_drive   = PIN_RELEASED;
    end else begin
      // every timed phase counts the same way
      if (cur.phase != PH_IDLE && cur.phase != PH_ARMED) begin
        nxt.tick_timer = wait_done ? '0 : timer_inc;
      end
      unique case (cur.phase)
        PH_ARMED: begin
          if (!line_level) begin
            nxt.tick_timer = '0;
            nxt.bit_index  = 4'd0;
            nxt.phase      = (cur.active_mode == MODE_SEND) ? PH_SWAIT : PH_HALF;
          end
        end
        PH_HALF: begin
          if (wait_done) begin
            if (cur.active_mode == MODE_REPLY) begin
              rs            = 1'b1;
              nxt.pin_drive = PIN_PULLUP;
              nxt.phase     = PH_GAP;
            end else begin
              nxt.phase = PH_RXDATA;
            end
          end
        end
        PH_GAP: begin
          if (wait_done) begin
            nxt.pin_drive = PIN_DRIVE_HI;
            nxt.phase     = PH_PREAMBLE;
          end
        end
        PH_PREAMBLE, PH_SPULL: begin
          if (wait_done) begin
            nxt.bit_index = 4'd0;
            nxt.pin_drive = tx_bit_first ? PIN_DRIVE_HI : PIN_DRIVE_LO;
            nxt.phase     = PH_TXDATA;
          end
        end
        PH_SWAIT: begin
          if (wait_done) begin
            nxt.pin_drive = PIN_PULLUP;
            nxt.phase     = PH_SPULL;
          end
        end
        PH_TXDATA: begin
          if (wait_done) begin
            if (idx_inc >= 4'd8) begin
              td            = (cur.active_mode == MODE_SEND);
              nxt.pin_drive = PIN_RELEASED;
              nxt.phase     = PH_IDLE;
              nxt.bit_index = 4'd0;
            end else begin
              nxt.bit_index = idx_inc;
              nxt.pin_drive = tx_bit_next ? PIN_DRIVE_HI : PIN_DRIVE_LO;
            end
          end
        end
        PH_RXDATA: begin
          if (wait_done) begin
            nxt.shift_reg = shift_in;
            if (idx_inc >= 4'd8) begin
              rv            = 1'b1;
              nxt.phase     = PH_IDLE;
              nxt.bit_index = 4'd0;
            end else begin
              nxt.bit_index = idx_inc;
            end
          end
        end
        default: begin
          nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.drive_enable  = nxt.pin_drive[1];
    res.drive_level   = nxt.pin_drive[0];
    res.busy_res      = (nxt.phase != PH_IDLE);
    res.reply_started = rs;
    res.tx_done       = td;
    res.rx_valid      = rv;
    res.rx_byte       = rv ? nxt.shift_reg : 8'd0;
  end

endmodule

[rtl/core/single_wire_serial_byte_engine.sv]
// ----------------------------------------------------------------------------
// single_wire_serial_byte_engine
// Half-duplex single-wire byte engine, 8 data bits msb first.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one tick of the bit timer. s_tuser says
// whether the request is a plain tick or arms the engine; s_tdata carries the
// mode, the byte to send and the sampled wire level. Every request gives
// exactly one result on the m_ channel: the pin drive for the wire, busy,
// the reply/done/receive pulses and the received byte.
// bit_period is set through cfg_we/cfg_wdata; the user must write it only while
// the engine is idle, as the block does not enforce it. The half-bit wait is bit_period >> 1.
// The result appears in the output register in the cycle after the request is
// taken. One request per cycle while the receiver takes results, set by the single
// state update between the state registers and the output register.
// When the receiver stalls, the result waits in the output register and
// s_tready drops until it is taken; nothing is lost or repeated.
// Reset: engine idle, wire released with pull-up off, bit_period 104,
// output channel empty.
// ----------------------------------------------------------------------------
module single_wire_serial_byte_engine import swsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [BitPeriodW-1:0] cfg_wdata,   // bit_period
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [InDataW-1:0]    s_tdata,     // op_mode[1:0], tx_byte[9:2], line_level[10]
  input  logic                  s_tuser,     // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OutDataW-1:0]   m_tdata      // drive_enable, drive_level, busy_res,
                                             // reply_started, tx_done, rx_valid,
                                             // rx_byte[13:6]
);

  logic [BitPeriodW-1:0] bit_period;
  engine_state_t         state;
  engine_state_t         state_next;
  engine_result_t        result_next;
  logic                  accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  swsb_step u_step (
    .cur        (state),
    .cmd        (s_tuser),
    .op_mode    (s_tdata[1:0]),
    .tx_byte    (s_tdata[9:2]),
    .line_level (s_tdata[10]),
    .bit_period (bit_period),
    .nxt        (state_next),
    .res        (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= BitPeriodReset;
    end else if (cfg_we) begin
      bit_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_IDLE;
      state.active_mode <= MODE_REPLY;
      state.tick_timer  <= '0;
      state.bit_index   <= 4'd0;
      state.shift_reg   <= 8'd0;
      state.pin_drive   <= PIN_RELEASED;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OutDataW'(result_next);
    end
  end

endmodule

[rtl/core/swsb_checker.sv]
// ----------------------------------------------------------------------------
// swsb_checker
// Port-level checks for the single-wire serial byte engine.
// ----------------------------------------------------------------------------
module swsb_checker import swsb_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OutDataW-1:0]   m_tdata
);

  // output channel is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // reply, done and receive pulses never coincide
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[5:3]))
    else $error("more than one event pulse in one result");

  // received byte reads zero outside the receive pulse
  a_rx_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[5] |-> m_tdata[13:6] == 8'd0)
    else $error("rx byte nonzero without rx valid");

  // a finished send or receive leaves the engine idle with the wire released
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[4] || m_tdata[5]) |-> !m_tdata[2] && !m_tdata[0])
    else $error("engine still busy or driving at end of transfer");

endmodule

bind single_wire_serial_byte_engine swsb_checker u_swsb_checker (.*);

[verif/single_wire_serial_byte_engine_tb.sv]
// ----------------------------------------------------------------------------
// single_wire_serial_byte_engine_tb
// Self-checking bench for the single-wire serial byte engine. A directed
// table walks reset behavior, ignored and re-issued arms and the start of each
// mode; random reply, send and receive transfers with noise and abandoned
// transfers follow over several bit periods. Every request is run through a
// cycle model of the engine and each result is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module single_wire_serial_byte_engine_tb;
  import swsb_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 80;

  // result constants: rx_byte, rx_valid, tx_done, reply_started, busy, level, enable
  localparam engine_result_t OUT_IDLE  = {8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam engine_result_t OUT_ARMED = {8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam engine_result_t OUT_REPLY_START =
    {8'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

  typedef struct packed {
    logic           cmd;
    logic [1:0]     op_mode;
    logic [7:0]     tx_byte;
    logic           line_level;
    logic           typed;
    engine_result_t want;
  } tick_req_t;

  typedef struct packed {
    logic                  cfg_write;
    logic [BitPeriodW-1:0] period;
    tick_req_t             req;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [BitPeriodW-1:0] cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [InDataW-1:0]    s_tdata;   // op_mode[1:0], tx_byte[9:2], line_level[10]
  logic                  s_tuser;   // cmd
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OutDataW-1:0]   m_tdata;   // drive_enable[0], drive_level[1], busy_res[2],
                                    // reply_started[3], tx_done[4], rx_valid[5],
                                    // rx_byte[13:6]

  // engine model state
  phase_t                eng_phase;
  logic [1:0]            eng_mode;
  logic [BitPeriodW-1:0] eng_timer;
  logic [3:0]            eng_bit;
  logic [7:0]            eng_shift;
  logic [1:0]            eng_pin;
  logic [BitPeriodW-1:0] bit_period_q;

  engine_result_t pin_result_q[$];
  tick_req_t      cur_req;
  logic           no_idle;
  logic           hold_off_pending;
  int             errors;
  int             requests;
  int             replies_seen;
  int             sends_seen;
  int             bytes_seen;
  int             settings_used;
  int unsigned    cycles = 0;

  single_wire_serial_byte_engine dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic logic timer_expired(input logic [BitPeriodW-1:0] len);
    eng_timer = eng_timer + 1'b1;
    if (len == '0 || eng_timer >= len) begin
      eng_timer = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] data_pin();
    return eng_shift[3'd7 - eng_bit[2:0]] ? PIN_DRIVE_HI : PIN_DRIVE_LO;
  endfunction

  function automatic engine_result_t engine_tick(input tick_req_t r);
    engine_result_t o;
    logic [BitPeriodW-1:0] half;
    o = '0;
    half = bit_period_q >> 1;
    if (r.cmd == CMD_ARM && r.op_mode != MODE_NONE) begin
      // an arm with any mode but none restarts, even mid-transfer
      eng_phase = PH_ARMED;
      eng_mode  = r.op_mode;
      eng_shift = (r.op_mode == MODE_RECV) ? 8'd0 : r.tx_byte;
      eng_timer = '0;
      eng_bit   = '0;
      eng_pin   = PIN_RELEASED;
    end else begin
      case (eng_phase)
        PH_ARMED: begin
          if (!r.line_level) begin
            eng_timer = '0;
            eng_bit   = '0;
            eng_phase = (eng_mode == MODE_SEND) ? PH_SWAIT : PH_HALF;
          end
        end
        PH_HALF: begin
          if (timer_expired(half)) begin
            if (eng_mode == MODE_REPLY) begin
              o.reply_started = 1'b1;
              eng_pin   = PIN_PULLUP;
              eng_phase = PH_GAP;
            end else begin
              eng_phase = PH_RXDATA;
            end
          end
        end
        PH_GAP: begin
          if (timer_expired(bit_period_q)) begin
            eng_pin   = PIN_DRIVE_HI;
            eng_phase = PH_PREAMBLE;
          end
        end
        PH_PREAMBLE, PH_SPULL: begin
          if (timer_expired(bit_period_q)) begin
            eng_bit   = '0;
            eng_pin   = data_pin();
            eng_phase = PH_TXDATA;
          end
        end
        PH_SWAIT: begin
          if (timer_expired(bit_period_q)) begin
            eng_pin   = PIN_PULLUP;
            eng_phase = PH_SPULL;
          end
        end
        PH_TXDATA: begin
          if (timer_expired(bit_period_q)) begin
            eng_bit = eng_bit + 1'b1;
            if (eng_bit >= 4'd8) begin
              if (eng_mode == MODE_SEND) o.tx_done = 1'b1;
              eng_pin   = PIN_RELEASED;
              eng_phase = PH_IDLE;
              eng_bit   = '0;
            end else begin
              eng_pin = data_pin();
            end
          end
        end
        PH_RXDATA: begin
          if (timer_expired(bit_period_q)) begin
            eng_shift = {eng_shift[6:0], r.line_level};
            eng_bit   = eng_bit + 1'b1;
            if (eng_bit >= 4'd8) begin
              o.rx_valid = 1'b1;
              o.rx_byte  = eng_shift;
              eng_phase  = PH_IDLE;
              eng_bit    = '0;
            end
          end
        end
        default: begin
          eng_phase = PH_IDLE;
        end
      endcase
    end
    o.drive_enable = eng_pin[1];
    o.drive_level  = eng_pin[0];
    o.busy_res     = (eng_phase != PH_IDLE);
    return o;
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // predict on accepted requests, check accepted results
  always @(posedge clk) begin
    engine_result_t o;
    engine_result_t got;
    engine_result_t want;
    if (rst) begin
      eng_phase    = PH_IDLE;
      eng_mode     = MODE_REPLY;
      eng_timer    = '0;
      eng_bit      = '0;
      eng_shift    = '0;
      eng_pin      = PIN_RELEASED;
      bit_period_q = BitPeriodReset;
    end else begin
      if (cfg_we) bit_period_q = cfg_wdata;
      if (s_tvalid && s_tready) begin
        o = engine_tick(cur_req);
        requests++;
        replies_seen += int'(o.reply_started);
        sends_seen   += int'(o.tx_done);
        bytes_seen   += int'(o.rx_valid);
        pin_result_q.push_back(cur_req.typed ? cur_req.want : o);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[13:0];
        if (pin_result_q.size() == 0) begin
          errors++;
          $display("%0t ns: result with nothing expected, got %h", $time, got);
        end else begin
          want = pin_result_q.pop_front();
          report_field("drive_enable", int'(want.drive_enable), int'(got.drive_enable));
          report_field("drive_level", int'(want.drive_level), int'(got.drive_level));
          report_field("busy_res", int'(want.busy_res), int'(got.busy_res));
          report_field("reply_started", int'(want.reply_started),
                       int'(got.reply_started));
          report_field("tx_done", int'(want.tx_done), int'(got.tx_done));
          report_field("rx_valid", int'(want.rx_valid), int'(got.rx_valid));
          report_field("rx_byte", int'(want.rx_byte), int'(got.rx_byte));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pin_result_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // called and returns at a falling edge; valid stays up for a back-to-back request
  task automatic offer_tick(input tick_req_t r);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_req   = r;
    s_tvalid <= 1'b1;
    s_tuser  <= r.cmd;
    s_tdata  <= {5'd0, r.line_level, r.tx_byte, r.op_mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // every request gives one result, so an empty queue means idle
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (pin_result_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_bit_period(input logic [BitPeriodW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  function automatic tick_req_t req_row(input logic cmd, input logic [1:0] mode,
                                        input logic [7:0] txb, input logic line);
    tick_req_t r;
    r = '0;
    r.cmd        = cmd;
    r.op_mode    = mode;
    r.tx_byte    = txb;
    r.line_level = line;
    return r;
  endfunction

  function automatic dir_row_t tick_row(input logic cmd, input logic [1:0] mode,
                                        input logic [7:0] txb, input logic line);
    dir_row_t d;
    d = '0;
    d.req = req_row(cmd, mode, txb, line);
    return d;
  endfunction

  function automatic dir_row_t typed_row(input logic cmd, input logic [1:0] mode,
                                         input logic [7:0] txb, input logic line,
                                         input engine_result_t want);
    dir_row_t d;
    d = tick_row(cmd, mode, txb, line);
    d.req.typed = 1'b1;
    d.req.want  = want;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input logic [BitPeriodW-1:0] period);
    dir_row_t d;
    d = '0;
    d.cfg_write = 1'b1;
    d.period    = period;
    return d;
  endfunction

  // one transfer with random content, a noise burst, or a transfer cut short
  task automatic random_transfer(input int bp, output int useful);
    tick_req_t r;
    int        kind;
    int        n;
    int        pre;
    kind    = $urandom_range(0, 9);
    no_idle = ($urandom_range(0, 4) == 0);
    if (kind == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        offer_tick(req_row(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end
      useful = n;
    end else begin
      offer_tick(req_row(CMD_ARM, 2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1))));
      pre = $urandom_range(0, 3);
      repeat (pre) offer_tick(req_row(CMD_TICK, MODE_REPLY, 8'd0, 1'b1));
      // start bit from the partner
      offer_tick(req_row(CMD_TICK, MODE_REPLY, 8'd0, 1'b0));
      n = (bp >> 1) + 10 * bp + 2;
      if (n > 120) n = 120;
      if (kind == 1) n = $urandom_range(1, n);
      repeat (n) begin
        r = req_row(CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        offer_tick(r);
      end
      useful = 2 + pre + n;
      repeat ($urandom_range(0, 2)) offer_tick(req_row(CMD_TICK, MODE_REPLY, 8'd0, 1'b1));
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_draw();
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    int       periods[5];
    int       cnt;
    int       k;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    s_tvalid         = 1'b0;
    s_tuser          = CMD_TICK;
    s_tdata          = '0;
    cur_req          = '0;
    no_idle          = 1'b0;
    hold_off_pending = 1'b0;
    errors           = 0;
    requests         = 0;
    replies_seen     = 0;
    sends_seen       = 0;
    bytes_seen       = 0;
    settings_used    = 1;
    periods          = '{2, 3, 4, 2, 5};

    // reset period first, then the shortest legal period
    dir_tab.push_back(typed_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1, OUT_IDLE));
    dir_tab.push_back(typed_row(CMD_ARM,  MODE_NONE,  8'hFF, 1'b0, OUT_IDLE));
    dir_tab.push_back(typed_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b0, OUT_IDLE));
    dir_tab.push_back(typed_row(CMD_ARM,  MODE_REPLY, 8'hFF, 1'b0, OUT_ARMED));
    dir_tab.push_back(typed_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1, OUT_ARMED));
    dir_tab.push_back(typed_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b0, OUT_ARMED));
    dir_tab.push_back(typed_row(CMD_ARM,  MODE_RECV,  8'h00, 1'b0, OUT_ARMED));
    dir_tab.push_back(typed_row(CMD_ARM,  MODE_NONE,  8'hFF, 1'b1, OUT_ARMED));
    dir_tab.push_back(cfg_row(16'd2));
    dir_tab.push_back(typed_row(CMD_ARM,  MODE_REPLY, 8'hA5, 1'b1, OUT_ARMED));
    dir_tab.push_back(typed_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b0, OUT_ARMED));
    dir_tab.push_back(typed_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1, OUT_REPLY_START));
    dir_tab.push_back(tick_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1));
    dir_tab.push_back(tick_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1));
    dir_tab.push_back(tick_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1));
    // re-arm in send mode in the middle of the reply
    dir_tab.push_back(tick_row(CMD_ARM,  MODE_SEND,  8'h00, 1'b1));
    dir_tab.push_back(tick_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b0));
    dir_tab.push_back(tick_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1));
    dir_tab.push_back(tick_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1));
    dir_tab.push_back(tick_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1));
    dir_tab.push_back(tick_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1));
    dir_tab.push_back(tick_row(CMD_ARM,  MODE_RECV,  8'hFF, 1'b1));
    dir_tab.push_back(tick_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b0));
    dir_tab.push_back(tick_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1));
    dir_tab.push_back(tick_row(CMD_TICK, MODE_REPLY, 8'h00, 1'b1));

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_write) begin
        settle_idle();
        write_bit_period(dir_tab[i].period);
      end else begin
        offer_tick(dir_tab[i].req);
      end
    end

    foreach (periods[p]) begin
      settle_idle();
      write_bit_period(16'(periods[p]));
      // first random phase: receiver holds off while requests keep coming
      if (p == 0) hold_off_pending = 1'b1;
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        random_transfer(periods[p], k);
        cnt += k;
      end
    end

    // longest period: transfers only get started
    settle_idle();
    write_bit_period(16'hFFFF);
    repeat (2) random_transfer(65535, k);

    settle_idle();
    repeat (10) @(negedge clk);
    $display("ran %0d requests over %0d bit-period settings, 2 up to 65535 ticks",
             requests, settings_used);
    $display("replies started %0d, sends finished %0d, bytes received %0d",
             replies_seen, sends_seen, bytes_seen);
    if (errors == 0 && pin_result_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/swsb_pkg.sv
rtl/core/swsb_step.sv
rtl/core/single_wire_serial_byte_engine.sv
rtl/core/swsb_checker.sv
verif/single_wire_serial_byte_engine_tb.sv
